FILE: sv/vbsp_pkg.sv
// shared types, constants and helper functions for the voc block stream parser
package vbsp_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_SKIP    = 3'd2,
        PH_BTYPE   = 3'd3,
        PH_BLEN    = 3'd4,
        PH_TCONST  = 3'd5,
        PH_PACKING = 3'd6,
        PH_DATA    = 3'd7
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_TCONST  = 2'd1,
        KIND_END     = 2'd2,
        KIND_BAD_HDR = 2'd3
    } kind_t;

    // header layout
    localparam logic [4:0]  SIG_LEN   = 5'd19;
    localparam logic [4:0]  EOF_IDX   = 5'd19;
    localparam logic [4:0]  OFS_LO    = 5'd20;
    localparam logic [4:0]  OFS_HI    = 5'd21;
    localparam logic [4:0]  HDR_LAST  = 5'd25;
    localparam logic [15:0] HDR_LEN   = 16'd26;
    localparam logic [7:0]  EOF_MARK  = 8'h1a;

    // block types
    localparam logic [7:0]  BLK_END   = 8'h00;
    localparam logic [7:0]  BLK_SOUND = 8'h01;
    localparam logic [7:0]  BLK_CONT  = 8'h02;

    // length byte positions
    localparam logic [1:0]  LEN_LAST  = 2'd2;

    // mixing
    localparam logic [9:0]  MIX_BIAS  = 10'd127;
    localparam logic [9:0]  MIX_TOP   = 10'd382;

    // expected signature character at a header position
    function automatic logic [7:0] sig_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            5'd0:  c = 8'h43;
            5'd1:  c = 8'h72;
            5'd2:  c = 8'h65;
            5'd3:  c = 8'h61;
            5'd4:  c = 8'h74;
            5'd5:  c = 8'h69;
            5'd6:  c = 8'h76;
            5'd7:  c = 8'h65;
            5'd8:  c = 8'h20;
            5'd9:  c = 8'h56;
            5'd10: c = 8'h6f;
            5'd11: c = 8'h69;
            5'd12: c = 8'h63;
            5'd13: c = 8'h65;
            5'd14: c = 8'h20;
            5'd15: c = 8'h46;
            5'd16: c = 8'h69;
            5'd17: c = 8'h6c;
            5'd18: c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // sample plus base minus bias, clamped to 0..255, when enabled; else the sample as it is
    function automatic logic [7:0] mix_sample(
        input logic       enable,
        input logic [7:0] fb,
        input logic [7:0] bb
    );
        logic [9:0] sum;
        logic [9:0] diff;
        logic [7:0] res;
        sum  = {2'b00, fb} + {2'b00, bb};
        diff = sum - MIX_BIAS;
        if (!enable)
        begin
            res = fb;
        end
        else if (sum < MIX_BIAS)
        begin
            res = 8'h00;
        end
        else if (sum > MIX_TOP)
        begin
            res = 8'hff;
        end
        else
        begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/vbsp_in_if.sv
// file byte channel carrying one raw byte per item
interface vbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic [7:0] base_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output base_byte,
                    output start_of_file, input ready);
    modport sink   (input valid, input file_byte, input base_byte,
                    input start_of_file, output ready);
endinterface

FILE: sv/vbsp_out_if.sv
// result channel carrying one parsed item
interface vbsp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;

    modport source (output valid, output out_kind, output out_byte, input ready);
    modport sink   (input valid, input out_kind, input out_byte, output ready);
endinterface

FILE: sv/voc_block_stream_parser.sv
// voc file stream parser: header check, offset skip, block walk, sample mixing
//
// file_chan takes one file byte per item, with a base byte for mixing and a
// start_of_file flag that restarts the parser on the first header byte.
// result_chan gives at most one item per input item: a sample, a new time
// constant, end of file, or a bad header marker (out_byte zero for the last two).
// cfg_we/cfg_wdata write mix_enable; write it only while the block is idle.
// A result is registered and appears on result_chan in the cycle after its byte is taken.
// Throughput: one byte per cycle while file_chan.ready is high; the parser state
// and the result register are both updated at the accepting edge.
// A single result register parts the two sides; file_chan.ready is high when
// that register is empty or being drained in the same cycle, so a stall on
// result_chan holds the input only while a result is waiting.
// Bytes that yield no result (header, skip, block headers, unknown bodies)
// never occupy the result register.
// Reset clears the parser to wait for a file start, empties the result
// register and clears mix_enable; bytes without start_of_file are then dropped.
module voc_block_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    vbsp_in_if.sink             file_chan,
    vbsp_out_if.source          result_chan,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import vbsp_pkg::*;

    // parser state
    phase_t      phase_reg,  phase_next;
    logic [4:0]  hidx_reg,   hidx_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [15:0] doff_reg,   doff_next;
    logic [15:0] skip_reg,   skip_next;
    logic [7:0]  bkind_reg,  bkind_next;
    logic [23:0] rem_reg,    rem_next;
    logic [1:0]  lbi_reg,    lbi_next;
    logic        mix_en_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [7:0]  out_byte_reg;

    // per-item working values
    logic        in_accept;
    logic        sof;
    logic [7:0]  fb;
    phase_t      eff_phase;
    logic [4:0]  eff_hidx;
    logic        eff_sig_ok;
    logic [15:0] eff_doff;
    logic [15:0] eff_skip;
    logic [7:0]  eff_bkind;
    logic [23:0] eff_rem;
    logic [1:0]  eff_lbi;
    logic        sig_ok_upd;
    logic [15:0] doff_upd;
    logic [23:0] rem_dec;
    logic [15:0] skip_inc;
    logic [1:0]  len_idx;
    logic [23:0] rem_len;
    logic        emit_valid;
    kind_t       emit_kind;
    logic [7:0]  emit_byte;

    // handshake
    assign in_accept       = file_chan.valid && file_chan.ready;
    assign file_chan.ready = !out_valid_reg || result_chan.ready;
    assign sof             = file_chan.start_of_file;
    assign fb              = file_chan.file_byte;

    // restart view of the state
    assign eff_phase  = sof ? PH_HEADER : phase_reg;
    assign eff_hidx   = sof ? 5'd0      : hidx_reg;
    assign eff_sig_ok = sof ? 1'b1      : sig_ok_reg;
    assign eff_doff   = sof ? 16'd0     : doff_reg;
    assign eff_skip   = sof ? 16'd0     : skip_reg;
    assign eff_bkind  = sof ? 8'd0      : bkind_reg;
    assign eff_rem    = sof ? 24'd0     : rem_reg;
    assign eff_lbi    = sof ? 2'd0      : lbi_reg;

    // header checks and offset capture
    assign sig_ok_upd = eff_sig_ok
                        && !(eff_hidx < SIG_LEN && fb != sig_char(eff_hidx))
                        && !(eff_hidx == EOF_IDX && fb != EOF_MARK);
    assign doff_upd   = (eff_hidx == OFS_LO) ? {eff_doff[15:8], fb} :
                        (eff_hidx == OFS_HI) ? {fb, eff_doff[7:0]} : eff_doff;

    // counters
    assign rem_dec  = (eff_rem == 24'd0) ? 24'd0 : eff_rem - 24'd1;
    assign skip_inc = eff_skip + 16'd1;
    assign len_idx  = (eff_lbi > LEN_LAST) ? LEN_LAST : eff_lbi;
    always_comb
    begin
        rem_len = eff_rem;
        unique case (len_idx)
            2'd0:    rem_len[7:0]   = eff_rem[7:0]   | fb;
            2'd1:    rem_len[15:8]  = eff_rem[15:8]  | fb;
            default: rem_len[23:16] = eff_rem[23:16] | fb;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        sig_ok_next = sig_ok_reg;
        doff_next   = doff_reg;
        skip_next   = skip_reg;
        bkind_next  = bkind_reg;
        rem_next    = rem_reg;
        lbi_next    = lbi_reg;
        if (in_accept)
        begin
            phase_next  = eff_phase;
            hidx_next   = eff_hidx;
            sig_ok_next = eff_sig_ok;
            doff_next   = eff_doff;
            skip_next   = eff_skip;
            bkind_next  = eff_bkind;
            rem_next    = eff_rem;
            lbi_next    = eff_lbi;
            unique case (eff_phase)
                PH_HEADER:
                begin
                    sig_ok_next = sig_ok_upd;
                    doff_next   = doff_upd;
                    if (eff_hidx >= HDR_LAST)
                    begin
                        if (!sig_ok_upd)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (doff_upd > HDR_LEN)
                        begin
                            skip_next  = HDR_LEN;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_BTYPE;
                        end
                    end
                    else
                    begin
                        hidx_next = eff_hidx + 5'd1;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_inc;
                    if (skip_inc >= eff_doff)
                    begin
                        phase_next = PH_BTYPE;
                    end
                end
                PH_BTYPE:
                begin
                    bkind_next = fb;
                    if (fb == BLK_END)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        rem_next   = 24'd0;
                        lbi_next   = 2'd0;
                        phase_next = PH_BLEN;
                    end
                end
                PH_BLEN:
                begin
                    rem_next = rem_len;
                    if (len_idx >= LEN_LAST)
                    begin
                        lbi_next = 2'd0;
                        if (eff_bkind == BLK_SOUND)
                        begin
                            phase_next = PH_TCONST;
                        end
                        else if (rem_len == 24'd0)
                        begin
                            phase_next = PH_BTYPE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        lbi_next = len_idx + 2'd1;
                    end
                end
                PH_TCONST:
                begin
                    rem_next   = rem_dec;
                    phase_next = PH_PACKING;
                end
                PH_PACKING:
                begin
                    rem_next   = rem_dec;
                    phase_next = (rem_dec != 24'd0) ? PH_DATA : PH_BTYPE;
                end
                PH_DATA:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 24'd0)
                    begin
                        phase_next = PH_BTYPE;
                    end
                end
                default:
                begin
                    phase_next = eff_phase;
                end
            endcase
        end
    end

    // result for the current byte
    always_comb
    begin
        emit_valid = 1'b0;
        emit_kind  = KIND_SAMPLE;
        emit_byte  = 8'h00;
        unique case (eff_phase)
            PH_HEADER:
            begin
                if (eff_hidx >= HDR_LAST && !sig_ok_upd)
                begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_BAD_HDR;
                end
            end
            PH_BTYPE:
            begin
                if (fb == BLK_END)
                begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_END;
                end
            end
            PH_TCONST:
            begin
                emit_valid = 1'b1;
                emit_kind  = KIND_TCONST;
                emit_byte  = fb;
            end
            PH_DATA:
            begin
                if (eff_bkind == BLK_SOUND || eff_bkind == BLK_CONT)
                begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_SAMPLE;
                    emit_byte  = mix_sample(mix_en_reg, fb, file_chan.base_byte);
                end
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = emit_valid;
        end
        else if (result_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hidx_reg      <= 5'd0;
            sig_ok_reg    <= 1'b1;
            doff_reg      <= 16'd0;
            skip_reg      <= 16'd0;
            bkind_reg     <= 8'd0;
            rem_reg       <= 24'd0;
            lbi_reg       <= 2'd0;
            mix_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hidx_reg      <= hidx_next;
            sig_ok_reg    <= sig_ok_next;
            doff_reg      <= doff_next;
            skip_reg      <= skip_next;
            bkind_reg     <= bkind_next;
            rem_reg       <= rem_next;
            lbi_reg       <= lbi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mix_en_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
        end
    end

    assign result_chan.valid    = out_valid_reg;
    assign result_chan.out_kind = out_kind_reg;
    assign result_chan.out_byte = out_byte_reg;

`ifndef NO_ASSERTIONS
    // a waiting result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && !result_chan.ready) |-> !file_chan.ready)
        else $error("input taken while result stalled");

    // a restart byte always lands in the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && sof) |=> (phase_reg == PH_HEADER))
        else $error("restart did not enter header phase");

    // end and bad header results leave the parser waiting for a new file
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit_valid && (emit_kind == KIND_END || emit_kind == KIND_BAD_HDR))
        |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after end or bad header");

    // header index never runs past the last header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (hidx_reg <= HDR_LAST))
        else $error("header index overrun");

    // length byte index stays within the three length bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        lbi_reg <= LEN_LAST)
        else $error("length byte index overrun");
`endif

endmodule

FILE: tb/voc_block_stream_parser_test.sv
// self-checking testbench for the voc block stream parser
module voc_block_stream_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vbsp_pkg::*;

    // stimulus table operations
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_HDR   = 2'd1,
        OP_BLOCK = 2'd2,
        OP_MIX   = 2'd3
    } stim_op_t;

    // one parsed item as seen on the result channel
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } parse_res_t;

    // header op: len[15:0] is the offset, bb the corrupted position (NO_BAD for none),
    // fb the corrupting value; block op: fb is the type, bb the body byte cap
    typedef struct {
        stim_op_t    op;
        logic [7:0]  fb;
        logic [7:0]  bb;
        logic        sof;
        logic [23:0] len;
        logic        typed;
        logic        got;
        kind_t       kind;
        logic [7:0]  data;
    } stim_row_t;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          PHASE_BYTES = 125;
    localparam logic [7:0]  NO_BAD      = 8'hff;
    // signature text, first character in the top byte
    localparam logic [151:0] HDR_SIG =
        152'h43_72_65_61_74_69_76_65_20_56_6f_69_63_65_20_46_69_6c_65;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    vbsp_in_if  file_chan ();
    vbsp_out_if result_chan ();

    voc_block_stream_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_chan   (file_chan),
        .result_chan (result_chan),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // parser state mirror
    phase_t      par_phase = PH_IDLE;
    logic [4:0]  hdr_pos   = 5'd0;
    logic        sig_good  = 1'b1;
    logic [15:0] data_ofs  = 16'd0;
    logic [15:0] skip_pos  = 16'd0;
    logic [7:0]  blk_type  = 8'd0;
    logic [23:0] blk_left  = 24'd0;
    logic [1:0]  len_pos   = 2'd0;
    logic        mix_on    = 1'b0;

    parse_res_t  pending_results [$];
    stim_row_t   dir_rows [$];

    // typed expectation overriding the prediction for one item
    logic        typed_row = 1'b0;
    logic        typed_got = 1'b0;
    parse_res_t  typed_res;

    int          tx_pct        = 0;
    int          rx_pct        = 0;
    int          rx_hold_left  = 0;
    int          bytes_parsed  = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count   = 0;
    parse_res_t  got_want;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] sig_byte(input int pos);
        return HDR_SIG[8 * (18 - pos) +: 8];
    endfunction

    // advance the parser mirror by one byte and give its result, if any
    function automatic void parse_byte(
        input  logic [7:0] fb,
        input  logic [7:0] bb,
        input  logic       sof,
        output logic       got,
        output parse_res_t res
    );
        int sum;
        got      = 1'b0;
        res.kind = KIND_SAMPLE;
        res.data = 8'h00;
        // a start flag restarts in any phase
        if (sof)
        begin
            hdr_pos   = 5'd0;
            sig_good  = 1'b1;
            data_ofs  = 16'd0;
            skip_pos  = 16'd0;
            blk_type  = 8'd0;
            blk_left  = 24'd0;
            len_pos   = 2'd0;
            par_phase = PH_HEADER;
        end
        unique case (par_phase)
            PH_HEADER:
            begin
                if (hdr_pos < SIG_LEN && fb != sig_byte(int'(hdr_pos)))
                    sig_good = 1'b0;
                if (hdr_pos == EOF_IDX && fb != EOF_MARK)
                    sig_good = 1'b0;
                if (hdr_pos == OFS_LO)
                    data_ofs[7:0] = fb;
                if (hdr_pos == OFS_HI)
                    data_ofs[15:8] = fb;
                if (hdr_pos >= HDR_LAST)
                begin
                    if (!sig_good)
                    begin
                        par_phase = PH_IDLE;
                        got       = 1'b1;
                        res.kind  = KIND_BAD_HDR;
                    end
                    else if (data_ofs > HDR_LEN)
                    begin
                        skip_pos  = HDR_LEN;
                        par_phase = PH_SKIP;
                    end
                    else
                    begin
                        par_phase = PH_BTYPE;
                    end
                end
                else
                begin
                    hdr_pos = hdr_pos + 5'd1;
                end
            end
            PH_SKIP:
            begin
                skip_pos = skip_pos + 16'd1;
                if (skip_pos >= data_ofs)
                    par_phase = PH_BTYPE;
            end
            PH_BTYPE:
            begin
                blk_type = fb;
                if (fb == BLK_END)
                begin
                    par_phase = PH_IDLE;
                    got       = 1'b1;
                    res.kind  = KIND_END;
                end
                else
                begin
                    blk_left  = 24'd0;
                    len_pos   = 2'd0;
                    par_phase = PH_BLEN;
                end
            end
            PH_BLEN:
            begin
                blk_left[8 * len_pos +: 8] = fb;
                if (len_pos == LEN_LAST)
                begin
                    len_pos = 2'd0;
                    if (blk_type == BLK_SOUND)
                        par_phase = PH_TCONST;
                    else if (blk_left == 24'd0)
                        par_phase = PH_BTYPE;
                    else
                        par_phase = PH_DATA;
                end
                else
                begin
                    len_pos = len_pos + 2'd1;
                end
            end
            PH_TCONST:
            begin
                if (blk_left != 24'd0)
                    blk_left = blk_left - 24'd1;
                par_phase = PH_PACKING;
                got       = 1'b1;
                res.kind  = KIND_TCONST;
                res.data  = fb;
            end
            PH_PACKING:
            begin
                if (blk_left != 24'd0)
                    blk_left = blk_left - 24'd1;
                par_phase = (blk_left != 24'd0) ? PH_DATA : PH_BTYPE;
            end
            PH_DATA:
            begin
                if (blk_left != 24'd0)
                    blk_left = blk_left - 24'd1;
                if (blk_left == 24'd0)
                    par_phase = PH_BTYPE;
                if (blk_type == BLK_SOUND || blk_type == BLK_CONT)
                begin
                    got      = 1'b1;
                    res.kind = KIND_SAMPLE;
                    res.data = fb;
                    // mixed sample: sum less bias, clamped to a byte
                    if (mix_on)
                    begin
                        sum = int'(fb) + int'(bb) - int'(MIX_BIAS);
                        if (sum < 0)
                            sum = 0;
                        if (sum > 255)
                            sum = 255;
                        res.data = sum[7:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // offer one byte, wait for it to be taken, then record what it should cause
    task automatic send_byte(input logic [7:0] fb, input logic [7:0] bb, input logic sof);
        int         gap;
        logic       got;
        logic       counted;
        parse_res_t res;
        gap = 0;
        while ($urandom_range(99) < tx_pct)
            gap++;
        if (gap > 0)
        begin
            file_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        file_chan.valid         <= 1'b1;
        file_chan.file_byte     <= fb;
        file_chan.base_byte     <= bb;
        file_chan.start_of_file <= sof;
        @(posedge clk);
        while (file_chan.ready !== 1'b1)
            @(posedge clk);
        counted = sof || (par_phase != PH_IDLE);
        parse_byte(fb, bb, sof, got, res);
        if (typed_row)
        begin
            got = typed_got;
            res = typed_res;
        end
        if (got)
            pending_results.push_back(res);
        if (counted)
            bytes_parsed++;
    endtask

    // 26-byte header, optionally with one corrupted byte, then the skip to the offset
    task automatic send_header(
        input logic [15:0] ofs,
        input int          bad_pos,
        input logic [7:0]  bad_val,
        input logic        typed_last
    );
        int         i;
        logic [7:0] b;
        for (i = 0; i < int'(HDR_LEN); i++)
        begin
            if (i < int'(SIG_LEN))
                b = sig_byte(i);
            else if (i == int'(EOF_IDX))
                b = EOF_MARK;
            else if (i == int'(OFS_LO))
                b = ofs[7:0];
            else if (i == int'(OFS_HI))
                b = ofs[15:8];
            else
                b = 8'($urandom_range(255));
            if (i == bad_pos)
                b = (bad_val == b) ? ~b : bad_val;
            typed_row = typed_last && (i == int'(HDR_LAST));
            send_byte(b, 8'($urandom_range(255)), i == 0);
        end
        typed_row = 1'b0;
        while (par_phase == PH_SKIP)
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    endtask

    // block header and up to body_cap body bytes
    task automatic send_block(input logic [7:0] kind, input logic [23:0] len, input int body_cap);
        int i;
        send_byte(kind, 8'($urandom_range(255)), 1'b0);
        for (i = 0; i < 3 && par_phase == PH_BLEN; i++)
            send_byte(len[8 * i +: 8], 8'($urandom_range(255)), 1'b0);
        i = 0;
        while (i < body_cap &&
               (par_phase == PH_TCONST || par_phase == PH_PACKING || par_phase == PH_DATA))
        begin
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
            i++;
        end
    endtask

    // stop offering and let every expected item come out
    task automatic wait_results_drained();
        file_chan.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mix enable write, only with the parser drained
    task automatic set_mix(input logic value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mix_on     = value;
    endtask

    task automatic add_row(
        input stim_op_t    op,
        input logic [7:0]  fb,
        input logic [7:0]  bb,
        input logic        sof,
        input logic [23:0] len,
        input logic        typed,
        input logic        got,
        input kind_t       kind,
        input logic [7:0]  data
    );
        stim_row_t r;
        r.op    = op;
        r.fb    = fb;
        r.bb    = bb;
        r.sof   = sof;
        r.len   = len;
        r.typed = typed;
        r.got   = got;
        r.kind  = kind;
        r.data  = data;
        dir_rows.push_back(r);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result_chan.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                result_chan.ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                result_chan.ready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid === 1'b1 && result_chan.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none, actual kind %0d byte %02h",
                         $time, result_chan.out_kind, result_chan.out_byte);
            end
            else
            begin
                got_want = pending_results.pop_front();
                if (result_chan.out_kind !== got_want.kind)
                begin
                    mismatch_count++;
                    $display("%0t: out_kind expected %0d actual %0d",
                             $time, got_want.kind, result_chan.out_kind);
                end
                if (result_chan.out_byte !== got_want.data)
                begin
                    mismatch_count++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, got_want.data, result_chan.out_byte);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** voc_block_stream_parser: FAILED **");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        stim_row_t   row;
        int          ph;
        int          phase_goal;
        int          r;
        int          bad;
        int          nblk;
        int          j;
        logic [15:0] ofs;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = 1'b0;
        file_chan.valid         = 1'b0;
        file_chan.file_byte     = 8'h00;
        file_chan.base_byte     = 8'h00;
        file_chan.start_of_file = 1'b0;
        typed_res.kind          = KIND_SAMPLE;
        typed_res.data          = 8'h00;

        // idle bytes straight after reset
        add_row(OP_BYTE,  8'h43, 8'h00, 1'b0, 24'd0, 1'b1, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'hff, 8'hff, 1'b0, 24'd0, 1'b1, 1'b0, KIND_SAMPLE, 8'h00);
        // offset zero, raw sample extremes
        add_row(OP_HDR,   8'h00, NO_BAD, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BLOCK, BLK_CONT, 8'd0, 1'b0, 24'd3, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'h00, 8'hff, 1'b0, 24'd0, 1'b1, 1'b1, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'hff, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_SAMPLE, 8'hff);
        add_row(OP_BYTE,  8'h5a, 8'ha5, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        // sound block of length zero still reads time constant and packing
        add_row(OP_BLOCK, BLK_SOUND, 8'd0, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'hff, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_TCONST, 8'hff);
        add_row(OP_BYTE,  8'h00, 8'h00, 1'b0, 24'd0, 1'b1, 1'b0, KIND_SAMPLE, 8'h00);
        // empty unknown block, then an unknown block with a body
        add_row(OP_BLOCK, 8'h07, 8'd0, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BLOCK, 8'hff, 8'd8, 1'b0, 24'd5, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        // sound block of length one
        add_row(OP_BLOCK, BLK_SOUND, 8'd0, 1'b0, 24'd1, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'h00, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_TCONST, 8'h00);
        add_row(OP_BYTE,  8'h33, 8'h00, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        // end block, then a byte ignored after it
        add_row(OP_BYTE,  BLK_END, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_END, 8'h00);
        add_row(OP_BYTE,  8'h7e, 8'h11, 1'b0, 24'd0, 1'b1, 1'b0, KIND_SAMPLE, 8'h00);
        // mixing on, offset exactly at the header end, clamped extremes
        add_row(OP_MIX,   8'h01, 8'h00, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_HDR,   8'h00, NO_BAD, 1'b0, 24'd26, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BLOCK, BLK_CONT, 8'd0, 1'b0, 24'd6, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'h00, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'hff, 8'hff, 1'b0, 24'd0, 1'b1, 1'b1, KIND_SAMPLE, 8'hff);
        add_row(OP_BYTE,  8'h7f, 8'h80, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  8'h01, 8'h7f, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        // restart mid block into a header with a bad end-of-file mark
        add_row(OP_HDR,   8'h1b, 8'd19, 1'b0, 24'd28, 1'b1, 1'b1, KIND_BAD_HDR, 8'h00);
        // restart while in the header, bad first character
        add_row(OP_BYTE,  8'h43, 8'h00, 1'b1, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_HDR,   8'h00, 8'd0, 1'b0, 24'hffff, 1'b1, 1'b1, KIND_BAD_HDR, 8'h00);
        // offset past the header end, huge unknown block cut short by a restart
        add_row(OP_MIX,   8'h00, 8'h00, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_HDR,   8'h00, NO_BAD, 1'b0, 24'd40, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BLOCK, 8'h80, 8'd4, 1'b0, 24'hffffff, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_HDR,   8'h00, NO_BAD, 1'b0, 24'd0, 1'b0, 1'b0, KIND_SAMPLE, 8'h00);
        add_row(OP_BYTE,  BLK_END, 8'h00, 1'b0, 24'd0, 1'b1, 1'b1, KIND_END, 8'h00);

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[n])
        begin
            row            = dir_rows[n];
            typed_got      = row.got;
            typed_res.kind = row.kind;
            typed_res.data = row.data;
            unique case (row.op)
                OP_BYTE:
                begin
                    typed_row = row.typed;
                    send_byte(row.fb, row.bb, row.sof);
                    typed_row = 1'b0;
                end
                OP_HDR:
                    send_header(row.len[15:0], (row.bb == NO_BAD) ? -1 : int'(row.bb),
                                row.fb, row.typed);
                OP_BLOCK:
                    send_block(row.fb, row.len, int'(row.bb));
                default:
                    set_mix(row.fb[0]);
            endcase
        end

        // long receiver hold-off while samples keep coming, then a full drain
        send_header(16'd0, -1, 8'h00, 1'b0);
        rx_hold_left = 150;
        send_block(BLK_CONT, 24'd40, 40);
        send_byte(BLK_END, 8'($urandom_range(255)), 1'b0);
        wait_results_drained();

        // random files under each idling pattern
        for (ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:       begin tx_pct = 0;  rx_pct = 0;  end
                1:       begin tx_pct = 45; rx_pct = 0;  end
                2:       begin tx_pct = 0;  rx_pct = 45; end
                default: begin tx_pct = 36; rx_pct = 36; end
            endcase
            set_mix(ph % 2 == 1);
            phase_goal = bytes_parsed + PHASE_BYTES;
            while (bytes_parsed < phase_goal)
            begin
                r = $urandom_range(99);
                if (r < 8)
                begin
                    // stray bytes, now and then a start flag
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  $urandom_range(9) == 0);
                end
                else
                begin
                    if (r < 20)
                    begin
                        ofs = 16'($urandom_range(65535));
                        bad = $urandom_range(19);
                    end
                    else
                    begin
                        bad = -1;
                        if ($urandom_range(9) < 6)
                            ofs = 16'($urandom_range(26));
                        else if ($urandom_range(9) == 0)
                            ofs = 16'($urandom_range(300, 27));
                        else
                            ofs = 16'($urandom_range(60, 27));
                    end
                    send_header(ofs, bad, 8'($urandom_range(255)), 1'b0);
                    if (par_phase == PH_BTYPE)
                    begin
                        nblk = $urandom_range(5, 1);
                        j    = 0;
                        while (j < nblk && par_phase == PH_BTYPE)
                        begin
                            r = $urandom_range(99);
                            if (r < 45)
                                send_block(BLK_SOUND, 24'($urandom_range(24)), 64);
                            else if (r < 80)
                                send_block(BLK_CONT, 24'($urandom_range(24)), 64);
                            else if (r < 95)
                                send_block(8'($urandom_range(255, 3)),
                                           24'($urandom_range(8)), 64);
                            else
                                send_block(8'($urandom_range(255, 3)),
                                           24'($urandom_range(24'hffffff)),
                                           $urandom_range(6));
                            j++;
                        end
                        if (par_phase == PH_BTYPE && $urandom_range(9) != 0)
                            send_byte(BLK_END, 8'($urandom_range(255)), 1'b0);
                        repeat ($urandom_range(2))
                            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
                    end
                end
            end
        end

        // wrap up
        wait_results_drained();
        if (mismatch_count == 0)
            $display("** voc_block_stream_parser: PASSED **");
        else
            $display("** voc_block_stream_parser: FAILED **");
        $finish;
    end

endmodule
